// ===== src/address_cache_with_stale_first_eviction_unit_assert.svh =====
// Assertion macros shared by the checkers of the address cache.
`ifndef ADDRESS_CACHE_WITH_STALE_FIRST_EVICTION_UNIT_ASSERT_SVH
`define ADDRESS_CACHE_WITH_STALE_FIRST_EVICTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address cache check failed");

// Next-cycle implication, checked outside reset.
`define ACSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address cache check failed");

`endif

// ===== src/acse_pkg.sv =====
// Shared types and codes of the address cache.
package acse_pkg;

    // Index width of the scan record, sized for the largest table.
    localparam int MAX_IDX_W       = 6;
    localparam int DEFAULT_ENTRIES = 8;

    // Entry state codes with a special meaning.
    localparam logic [2:0] ENT_NONE  = 3'd0;
    localparam logic [2:0] ENT_STALE = 3'd3;
    localparam logic [2:0] ENT_PERM  = 3'd6;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_SET    = 2'd2,
        KIND_FLUSH  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    // Record handed from cell to cell along the chain.
    typedef struct packed {
        logic                 active;
        t_kind                kind;
        logic [31:0]          addr;
        logic [2:0]           slot;
        logic [2:0]           new_state;
        logic [31:0]          now;
        logic                 have_free;
        logic [MAX_IDX_W-1:0] free_idx;
        logic                 hit;
        logic [MAX_IDX_W-1:0] hit_idx;
        logic                 have_cand;
        logic                 cand_stale;
        logic [MAX_IDX_W-1:0] cand_idx;
        logic [31:0]          cand_age;
    } t_scan;

    // Write command broadcast to every cell.
    typedef struct packed {
        logic                 wr;
        logic                 wr_addr;
        logic                 flush;
        logic [MAX_IDX_W-1:0] idx;
        logic [2:0]           state;
        logic [31:0]          addr;
        logic [31:0]          stamp;
    } t_wr_cmd;

endpackage

// ===== src/acse_entry.sv =====
// One cache entry with its stage of the scan chain.
module acse_entry #(
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  acse_pkg::t_scan   i_scan,
    input  acse_pkg::t_wr_cmd i_wr,
    output acse_pkg::t_scan   o_scan
);

    localparam logic [acse_pkg::MAX_IDX_W-1:0] MyIdx = acse_pkg::MAX_IDX_W'(CELL_IDX);

    logic [2:0]      r_state;
    logic [31:0]     r_addr;
    logic [31:0]     r_time;
    acse_pkg::t_scan r_out;
    acse_pkg::t_scan n_out;

    logic        w_used;
    logic        w_stale;
    logic        w_take;
    logic [31:0] w_age;

    // Hold the entry state; flush frees every non-permanent entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acse_pkg::ENT_NONE;
        end else if (i_wr.flush) begin
            if (r_state != acse_pkg::ENT_PERM) begin
                r_state <= acse_pkg::ENT_NONE;
            end
        end else if (i_wr.wr && i_wr.idx == MyIdx) begin
            r_state <= i_wr.state;
        end
    end

    // Hold address and timestamp
    always_ff @(posedge i_clk) begin
        if (i_wr.flush) begin
            if (r_state != acse_pkg::ENT_PERM) begin
                r_time <= i_wr.stamp;
            end
        end else if (i_wr.wr && i_wr.idx == MyIdx) begin
            r_time <= i_wr.stamp;
            if (i_wr.wr_addr) begin
                r_addr <= i_wr.addr;
            end
        end
    end

    // Fold this entry into the passing record
    always_comb begin
        n_out   = i_scan;
        w_used  = (r_state != acse_pkg::ENT_NONE);
        w_stale = (r_state == acse_pkg::ENT_STALE);
        w_age   = i_scan.now - r_time;
        w_take  = 1'b0;

        if (!i_scan.have_free && !w_used) begin
            n_out.have_free = 1'b1;
            n_out.free_idx  = MyIdx;
        end
        if (!i_scan.hit && w_used && r_addr == i_scan.addr) begin
            n_out.hit     = 1'b1;
            n_out.hit_idx = MyIdx;
        end
        // Victim: stale first, then oldest, earlier cell wins ties
        if (w_used && r_state != acse_pkg::ENT_PERM) begin
            if (!i_scan.have_cand) begin
                w_take = 1'b1;
            end else if (w_stale && !i_scan.cand_stale) begin
                w_take = 1'b1;
            end else if (w_stale == i_scan.cand_stale && w_age > i_scan.cand_age) begin
                w_take = 1'b1;
            end
        end
        if (w_take) begin
            n_out.have_cand  = 1'b1;
            n_out.cand_stale = w_stale;
            n_out.cand_idx   = MyIdx;
            n_out.cand_age   = w_age;
        end
    end

    // Advance the record to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.active <= 1'b0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_scan = r_out;

endmodule

// ===== src/acse_ctrl.sv =====
// Request launch, decision, write-back and result register of the cache.
module acse_ctrl #(
    parameter int ENTRIES = acse_pkg::DEFAULT_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  acse_pkg::t_kind   i_kind,
    input  logic [31:0]       i_addr,
    input  logic [2:0]        i_slot,
    input  logic [2:0]        i_new_state,
    input  logic [31:0]       i_now,
    output acse_pkg::t_scan   o_launch,
    input  acse_pkg::t_scan   i_done,
    output acse_pkg::t_wr_cmd o_wr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_found,
    output logic [2:0]        o_slot,
    output logic              o_evicted
);

    acse_pkg::t_state r_state;
    acse_pkg::t_state n_state;

    logic       r_found, n_found;
    logic [2:0] r_slot, n_slot;
    logic       r_evicted, n_evicted;

    logic       r_out_valid;
    logic       r_out_found;
    logic [2:0] r_out_slot;
    logic       r_out_evicted;

    logic w_accept;
    logic w_decide;
    logic w_load;

    assign o_in_ready = (r_state == acse_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_decide   = (r_state == acse_pkg::S_SCAN) && i_done.active;
    assign w_load     = (r_state == acse_pkg::S_OUT) && (!r_out_valid || i_out_ready);

    // Start a fresh record at the head of the chain
    always_comb begin
        o_launch           = '0;
        o_launch.active    = w_accept;
        o_launch.kind      = i_kind;
        o_launch.addr      = i_addr;
        o_launch.slot      = i_slot;
        o_launch.new_state = i_new_state;
        o_launch.now       = i_now;
    end

    // Decide the result and the write-back from the finished record
    always_comb begin
        n_found    = 1'b0;
        n_slot     = 3'd0;
        n_evicted  = 1'b0;
        o_wr       = '0;
        o_wr.state = i_done.new_state;
        o_wr.addr  = i_done.addr;
        o_wr.stamp = i_done.now;
        if (w_decide) begin
            unique case (i_done.kind)
                acse_pkg::KIND_LOOKUP: begin
                    if (i_done.hit) begin
                        n_found = 1'b1;
                        n_slot  = i_done.hit_idx[2:0];
                    end
                end
                acse_pkg::KIND_ALLOC: begin
                    if (i_done.have_free) begin
                        o_wr.wr      = 1'b1;
                        o_wr.wr_addr = 1'b1;
                        o_wr.idx     = i_done.free_idx;
                        n_found      = 1'b1;
                        n_slot       = i_done.free_idx[2:0];
                    end else if (i_done.have_cand) begin
                        o_wr.wr      = 1'b1;
                        o_wr.wr_addr = 1'b1;
                        o_wr.idx     = i_done.cand_idx;
                        n_found      = 1'b1;
                        n_slot       = i_done.cand_idx[2:0];
                        n_evicted    = 1'b1;
                    end
                end
                acse_pkg::KIND_SET: begin
                    if (int'(i_done.slot) < ENTRIES) begin
                        o_wr.wr  = 1'b1;
                        o_wr.idx = acse_pkg::MAX_IDX_W'(i_done.slot);
                    end
                end
                acse_pkg::KIND_FLUSH: begin
                    o_wr.flush = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acse_pkg::S_IDLE: if (w_accept) n_state = acse_pkg::S_SCAN;
            acse_pkg::S_SCAN: if (w_decide) n_state = acse_pkg::S_OUT;
            acse_pkg::S_OUT:  if (w_load)   n_state = acse_pkg::S_IDLE;
            default:          n_state = acse_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the decided result until the output register is free
    always_ff @(posedge i_clk) begin
        if (w_decide) begin
            r_found   <= n_found;
            r_slot    <= n_slot;
            r_evicted <= n_evicted;
        end
    end

    // Output register: load on a free slot, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_found   <= r_found;
            r_out_slot    <= r_slot;
            r_out_evicted <= r_evicted;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_slot      = r_out_slot;
    assign o_evicted   = r_out_evicted;

endmodule

// ===== src/address_cache_with_stale_first_eviction_unit.sv =====
// Top level of the address cache: entry chain and controller.
//
//  channel  | direction | tdata / tuser contents
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tuser: kind; tdata: ip_addr, slot, new_state, now
//  m_axis   | out       | tdata: found, result_slot, evicted
//
// Every request walks a record through the ENTRIES cells, one cell a cycle, and
// the controller then decides and writes back; the next transfer is accepted
// only once the result of the last one has been loaded into the output register.
// Reset is synchronous, active low, and frees every entry at once.
// A stalled output holds its result; a further request is taken meanwhile and
// waits for the output register once its scan is done.
module address_cache_with_stale_first_eviction_unit #(
    parameter int ENTRIES = acse_pkg::DEFAULT_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // ip_addr[31:0], slot[34:32], new_state[37:35],
                                       // now[69:38], zero[71:70]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // found[0], result_slot[3:1], evicted[4], zero[7:5]
);

    acse_pkg::t_scan   w_chain [ENTRIES+1];
    acse_pkg::t_wr_cmd w_wr;

    logic       w_found;
    logic [2:0] w_slot;
    logic       w_evicted;

    acse_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (acse_pkg::t_kind'(s_axis_tuser)),
        .i_addr      (s_axis_tdata[31:0]),
        .i_slot      (s_axis_tdata[34:32]),
        .i_new_state (s_axis_tdata[37:35]),
        .i_now       (s_axis_tdata[69:38]),
        .o_launch    (w_chain[0]),
        .i_done      (w_chain[ENTRIES]),
        .o_wr        (w_wr),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_found     (w_found),
        .o_slot      (w_slot),
        .o_evicted   (w_evicted)
    );

    // Row of entry cells, each passing the scan record on
    for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
        acse_entry #(
            .CELL_IDX(g)
        ) u_entry (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_scan (w_chain[g]),
            .i_wr   (w_wr),
            .o_scan (w_chain[g+1])
        );
    end

    assign m_axis_tdata = {3'b000, w_evicted, w_slot, w_found};

endmodule

// ===== src/acse_checker.sv =====
// Port-level checks of the address cache, bound to the top level.
`include "address_cache_with_stale_first_eviction_unit_assert.svh"

module acse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // One request at a time: no transfer right after another
    `ACSE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A miss reports no slot and no eviction
    `ACSE_ASSERT_NOW(a_miss_clean, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[4:1] == 4'd0)

    // An eviction is always a successful allocation
    `ACSE_ASSERT_NOW(a_evict_found, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[4], m_axis_tdata[0])

    // A stalled result holds
    `ACSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind address_cache_with_stale_first_eviction_unit acse_checker u_acse_checker (.*);

// ===== verif/acse_response_checker.sv =====
// Response checker for the address cache: predicts every transfer and compares results.
module acse_response_checker #(
    parameter int ENTRIES = acse_pkg::DEFAULT_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [71:0] i_req_tdata,   // ip_addr[31:0], slot[34:32], new_state[37:35],
                                       // now[69:38], zero[71:70]
    input  logic [1:0]  i_req_tuser,   // kind[1:0]
    input  logic        i_rsp_tvalid,
    input  logic        i_rsp_tready,
    input  logic [7:0]  i_rsp_tdata,   // found[0], result_slot[3:1], evicted[4], zero[7:5]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic       found;
        logic [2:0] slot;
        logic       evicted;
    } t_cache_resp;

    // Shadow copy of the cache table
    logic [2:0]  ent_state [ENTRIES];
    logic [31:0] ent_ip    [ENTRIES];
    logic [31:0] ent_stamp [ENTRIES];

    t_cache_resp expected_resp_q [$];
    int          fail_total = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            ent_state[i] = acse_pkg::ENT_NONE;
            ent_ip[i]    = '0;
            ent_stamp[i] = '0;
        end
    end

    // Apply one request to the shadow table and return the response it causes.
    function automatic t_cache_resp resolve_request(acse_pkg::t_kind kind, logic [31:0] ip,
                                                    logic [2:0] slot, logic [2:0] st,
                                                    logic [31:0] now);
        t_cache_resp rsp;
        bit          have;
        bit          victim;
        bit          stale_i;
        bit          stale_p;
        int          pick;
        logic [31:0] age_i;
        logic [31:0] age_p;
        rsp    = '0;
        have   = 1'b0;
        victim = 1'b0;
        pick   = 0;
        case (kind)
            acse_pkg::KIND_LOOKUP: begin
                // first in-use entry with a matching address wins
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!have && ent_state[i] != acse_pkg::ENT_NONE && ent_ip[i] == ip) begin
                        have = 1'b1;
                        pick = i;
                    end
                end
                if (have) begin
                    rsp.found = 1'b1;
                    rsp.slot  = pick[2:0];
                end
            end
            acse_pkg::KIND_ALLOC: begin
                // take the first free entry
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!have && ent_state[i] == acse_pkg::ENT_NONE) begin
                        have = 1'b1;
                        pick = i;
                    end
                end
                // otherwise evict: stale first, then oldest, lower index on ties
                if (!have) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (ent_state[i] != acse_pkg::ENT_PERM) begin
                            if (!have) begin
                                have = 1'b1;
                                pick = i;
                            end else begin
                                stale_i = (ent_state[i] == acse_pkg::ENT_STALE);
                                stale_p = (ent_state[pick] == acse_pkg::ENT_STALE);
                                age_i   = now - ent_stamp[i];
                                age_p   = now - ent_stamp[pick];
                                if (stale_i && !stale_p) begin
                                    pick = i;
                                end else if (stale_i == stale_p && age_i > age_p) begin
                                    pick = i;
                                end
                            end
                        end
                    end
                    victim = have;
                end
                if (have) begin
                    ent_ip[pick]    = ip;
                    ent_state[pick] = st;
                    ent_stamp[pick] = now;
                    rsp.found       = 1'b1;
                    rsp.slot        = pick[2:0];
                    rsp.evicted     = victim;
                end
            end
            acse_pkg::KIND_SET: begin
                if (int'(slot) < ENTRIES) begin
                    ent_state[slot] = st;
                    ent_stamp[slot] = now;
                end
            end
            default: begin
                // flush frees everything but permanent entries
                for (int i = 0; i < ENTRIES; i++) begin
                    if (ent_state[i] != acse_pkg::ENT_PERM) begin
                        ent_state[i] = acse_pkg::ENT_NONE;
                        ent_stamp[i] = now;
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            fail_total++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Retire result transfers first, then record newly accepted requests.
    always @(posedge i_clk) begin
        t_cache_resp want;
        t_cache_resp got;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                ent_state[i] = acse_pkg::ENT_NONE;
            end
            expected_resp_q.delete();
        end else begin
            if (i_rsp_tvalid && i_rsp_tready) begin
                got.found   = i_rsp_tdata[0];
                got.slot    = i_rsp_tdata[3:1];
                got.evicted = i_rsp_tdata[4];
                if (expected_resp_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: result expected none actual found=%0d slot=%0d evicted=%0d",
                             $time, got.found, got.slot, got.evicted);
                end else begin
                    want = expected_resp_q.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("result_slot", want.slot, got.slot);
                    check_field("evicted", want.evicted, got.evicted);
                end
            end
            if (i_req_tvalid && i_req_tready) begin
                expected_resp_q.push_back(resolve_request(acse_pkg::t_kind'(i_req_tuser),
                                                          i_req_tdata[31:0],
                                                          i_req_tdata[34:32],
                                                          i_req_tdata[37:35],
                                                          i_req_tdata[69:38]));
            end
        end
        o_pending    <= expected_resp_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== verif/tb_address_cache_with_stale_first_eviction_unit.sv =====
// Testbench top for the address cache: clock, reset, stimulus and verdict.
module tb_address_cache_with_stale_first_eviction_unit;

    localparam int ENTRIES         = acse_pkg::DEFAULT_ENTRIES;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 4 * (ENTRIES + 2);
    localparam int POOL_SIZE       = 16;

    // State codes without a meaning of their own to the block
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_REACHABLE  = 3'd2;
    localparam logic [2:0] ST_DELAY      = 3'd4;
    localparam logic [2:0] ST_PROBE      = 3'd5;
    localparam logic [2:0] ST_RESERVED   = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [71:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          hold_left   = 0;
    logic        steady      = 1'b0;
    logic        hold_req    = 1'b0;
    logic        hold_taken  = 1'b0;
    logic [31:0] ip_pool [POOL_SIZE];
    logic [31:0] tick;

    always #5 i_clk = ~i_clk;

    address_cache_with_stale_first_eviction_unit #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    acse_response_checker #(
        .ENTRIES(ENTRIES)
    ) response_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_tvalid(s_axis_tvalid),
        .i_req_tready(s_axis_tready),
        .i_req_tdata (s_axis_tdata),
        .i_req_tuser (s_axis_tuser),
        .i_rsp_tvalid(m_axis_tvalid),
        .i_rsp_tready(m_axis_tready),
        .i_rsp_tdata (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, calm during the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_OFF_CYCLES;
            hold_taken    <= 1'b1;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 8);
        end
    end

    // Offer one request and hold it until the transfer completes.
    task automatic issue_request(acse_pkg::t_kind kind, logic [31:0] ip, logic [2:0] slot,
                                 logic [2:0] st, logic [31:0] now);
        while (!steady && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, now, st, slot, ip};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Mostly lookups and allocations over a small address pool so that hits and
    // evictions are common; time creeps forward and now and then jumps.
    task automatic issue_random_request();
        int              roll;
        acse_pkg::t_kind kind;
        logic [31:0]     ip;
        roll = $urandom_range(99);
        if (roll < 36) begin
            kind = acse_pkg::KIND_LOOKUP;
        end else if (roll < 73) begin
            kind = acse_pkg::KIND_ALLOC;
        end else if (roll < 97) begin
            kind = acse_pkg::KIND_SET;
        end else begin
            kind = acse_pkg::KIND_FLUSH;
        end
        if ($urandom_range(99) < 85) begin
            ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            ip = $urandom();
        end
        if ($urandom_range(99) < 3) begin
            tick = $urandom();
        end else begin
            tick = tick + $urandom_range(40);
        end
        issue_request(kind, ip, 3'($urandom_range(7)), 3'($urandom_range(7)), tick);
    endtask

    initial begin
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        ip_pool[2] = 32'hC0A8_0001;
        ip_pool[3] = 32'hC0A8_0002;
        for (int i = 4; i < POOL_SIZE; i++) begin
            ip_pool[i] = $urandom();
        end
        tick = 32'hFFFF_FF00;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: miss, harmless free write, flush
        issue_request(acse_pkg::KIND_LOOKUP, 32'h0000_0000, 3'd0, acse_pkg::ENT_NONE, 32'd0);
        issue_request(acse_pkg::KIND_SET, 32'h1234_5678, 3'd5, acse_pkg::ENT_NONE, 32'd0);
        issue_request(acse_pkg::KIND_FLUSH, 32'hFFFF_FFFF, 3'd7, ST_RESERVED, 32'hFFFF_FFFF);

        // Fill every entry in order, time wrapping part way through
        issue_request(acse_pkg::KIND_ALLOC, 32'h0000_0000, 3'd7, ST_INCOMPLETE, 32'hFFFF_FFF0);
        issue_request(acse_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 3'd0, ST_REACHABLE, 32'hFFFF_FFF4);
        issue_request(acse_pkg::KIND_ALLOC, 32'hC0A8_0001, 3'd3, acse_pkg::ENT_STALE,
                      32'hFFFF_FFFC);
        issue_request(acse_pkg::KIND_ALLOC, 32'hC0A8_0002, 3'd1, ST_DELAY, 32'd2);
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[4], 3'd2, ST_PROBE, 32'd3);
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[5], 3'd4, ST_RESERVED, 32'd5);
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[6], 3'd6, acse_pkg::ENT_STALE, 32'd6);
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[7], 3'd5, ST_REACHABLE, 32'd7);

        // Hits on the extreme addresses
        issue_request(acse_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 3'd0, acse_pkg::ENT_NONE, 32'd8);
        issue_request(acse_pkg::KIND_LOOKUP, 32'h0000_0000, 3'd0, acse_pkg::ENT_NONE, 32'd8);

        // Full table: older stale entry, younger stale entry, then the oldest
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[8], 3'd0, ST_REACHABLE, 32'd10);
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[9], 3'd0, ST_REACHABLE, 32'd10);
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[10], 3'd0, ST_REACHABLE, 32'd10);

        // Everything permanent: allocation fails and flush frees nothing
        for (int i = 0; i < ENTRIES; i++) begin
            issue_request(acse_pkg::KIND_SET, 32'h0000_0000, 3'(i), acse_pkg::ENT_PERM, 32'd20);
        end
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[11], 3'd0, ST_REACHABLE, 32'd21);
        issue_request(acse_pkg::KIND_FLUSH, 32'h0000_0000, 3'd0, acse_pkg::ENT_NONE, 32'd22);
        issue_request(acse_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 3'd0, acse_pkg::ENT_NONE, 32'd23);

        // Allocation that leaves the entry free, then a lookup that must miss it
        issue_request(acse_pkg::KIND_SET, 32'h0000_0000, 3'd4, acse_pkg::ENT_NONE, 32'd24);
        issue_request(acse_pkg::KIND_ALLOC, ip_pool[12], 3'd0, acse_pkg::ENT_NONE, 32'd25);
        issue_request(acse_pkg::KIND_LOOKUP, ip_pool[12], 3'd0, acse_pkg::ENT_NONE, 32'd26);

        // Random traffic with one long hold-off and one calm stretch
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 300) hold_req <= 1'b1;
            if (n == 600) steady <= 1'b1;
            if (n == 900) steady <= 1'b0;
            issue_random_request();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        // Drain outstanding results, then watch for strays
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
